// ===== rtl/sida_pkg.sv =====
// shared types and constants for the signed integer to decimal ascii core
`timescale 1ns / 1ps

package sida_pkg;

    localparam int DIGIT_COUNT_DEF = 10;
    localparam int VALUE_W         = 32;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 4;

    // reciprocal of ten, exact for every 32-bit dividend after the shift
    localparam logic [VALUE_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam int                 QUOT_SHIFT = 35;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_NL    = 8'h0A;

    typedef enum logic [1:0] {
        CH_MINUS,
        CH_DIGIT,
        CH_NL
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      emit;
        char_sel_t sel;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic neg;
        logic line;
        logic div_last;
        logic idx_zero;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/sida_datapath.sv =====
// datapath: magnitude, divide by ten, digit store and output register
`timescale 1ns / 1ps

module sida_datapath
    import sida_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dp_cmd_t                   cmd,
    output dp_sts_t                   sts,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      s_mode,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CHAR_W-1:0]         m_char_out,
    output logic                      m_last
);

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIGIT_COUNT - 1);

    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic [DIGIT_W-1:0]   digit_reg [DIGIT_COUNT];
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 neg_reg, neg_next;
    logic                 line_reg, line_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 valid_reg, valid_next;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   rem;
    logic [VALUE_W-1:0]   value_u;
    logic                 div_last;
    logic [DIGIT_W-1:0]   cur_digit;

    assign value_u  = VALUE_W'(s_value);
    assign prod     = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP_10};
    assign quot     = VALUE_W'(prod >> QUOT_SHIFT);
    assign rem      = mag_reg - ((quot << 3) + (quot << 1));
    // once the quotient is zero every higher digit is a leading zero
    assign div_last = (quot == '0) || (idx_reg == IDX_MAX);
    assign cur_digit = digit_reg[idx_reg];

    always_comb begin
        mag_next   = mag_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        line_next  = line_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg;

        if (cmd.load) begin
            neg_next  = value_u[VALUE_W-1];
            mag_next  = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
            line_next = s_mode;
            idx_next  = '0;
        end else if (cmd.div_step) begin
            mag_next = quot;
            if (!div_last) begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end

        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (cmd.emit) begin
            valid_next = 1'b1;
            last_next  = cmd.last;
            unique case (cmd.sel)
                CH_MINUS: char_next = ASCII_MINUS;
                CH_DIGIT: begin
                    char_next = ASCII_ZERO + CHAR_W'(cur_digit);
                    if (idx_reg != '0) begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                CH_NL:    char_next = ASCII_NL;
                default:  char_next = ASCII_NL;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            neg_reg   <= 1'b0;
            line_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            neg_reg   <= neg_next;
            line_reg  <= line_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (cmd.div_step && !cmd.load) begin
            digit_reg[idx_reg] <= rem[DIGIT_W-1:0];
        end
    end

    assign sts.neg      = neg_reg;
    assign sts.line     = line_reg;
    assign sts.div_last = div_last;
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.out_free = !valid_reg || m_ready;

    assign m_valid    = valid_reg;
    assign m_char_out = char_reg;
    assign m_last     = last_reg;

endmodule

// ===== rtl/sida_ctrl.sv =====
// controller: sequences conversion and character emission for one request
`timescale 1ns / 1ps

module sida_ctrl
    import sida_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SIGN  = 3'd2;
    localparam logic [2:0] ST_DIGIT = 3'd3;
    localparam logic [2:0] ST_NL    = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.emit     = 1'b0;
        cmd.sel      = CH_DIGIT;
        cmd.last     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = sts.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                cmd.sel = CH_MINUS;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                cmd.sel  = CH_DIGIT;
                cmd.last = sts.idx_zero && !sts.line;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.idx_zero) begin
                        state_next = sts.line ? ST_NL : ST_IDLE;
                    end
                end
            end
            ST_NL: begin
                cmd.sel  = CH_NL;
                cmd.last = 1'b1;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // never overwrite a character that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("character emitted while output register busy");

    // the final character always hands control back to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> state_reg == ST_IDLE)
        else $error("last character did not end the request");

    // a minus sign is never the end of a request
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.sel == CH_MINUS) |-> !cmd.last)
        else $error("minus sign flagged as last");

    // accepting a request starts the divide phase
    a_load_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_DIV)
        else $error("request accepted without starting conversion");

endmodule

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// Top level: signed 32-bit value in, decimal ascii characters out.
// A value is converted by repeated divide-by-ten (one reciprocal multiply per
// cycle), then its characters are emitted one per cycle while m_ready is high.
// A new request is accepted only after the previous one has emitted its last character.
// Synchronous active-low reset empties the output register and returns to idle.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core
    import sida_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      s_mode,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CHAR_W-1:0]         m_char_out,
    output logic                      m_last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    sida_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sida_datapath #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_value    (s_value),
        .s_mode     (s_mode),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_out (m_char_out),
        .m_last     (m_last)
    );

endmodule
